[design/byte_range_lock_table_top_macros.svh]
// Assertion helpers shared by the checker of the lock table.
`ifndef BYTE_RANGE_LOCK_TABLE_TOP_MACROS_SVH
`define BYTE_RANGE_LOCK_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRLT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock table check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BRLT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock table check failed one cycle later");

`endif

[design/brlt_pkg.sv]
package brlt_pkg;

    localparam int LOCK_SLOTS_DEF = 16;
    localparam int FILE_COUNT_DEF = 64;

    localparam int FILE_W   = 6;
    localparam int FILE_IDS = 1 << FILE_W;
    localparam int START_W  = 48;
    localparam int LENGTH_W = 32;
    localparam int LAST_W   = 49;
    localparam int SLOT_OUT_W = 4;
    localparam int WAKE_W   = 16;
    localparam int STATUS_W = 2;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_LEN = 2'd3;

    typedef struct packed {
        logic              alloc;
        logic [FILE_W-1:0] file;
        logic [START_W-1:0] first;
        logic [LAST_W-1:0] last;
        logic              shared;
    } t_cell_cmd;

    typedef struct packed {
        logic valid;
        logic hit;
        logic wake;
        logic pick;
    } t_cell_stat;

endpackage

[design/brlt_cell.sv]
module brlt_cell
    import brlt_pkg::*;
#(
    parameter int SLOTS = LOCK_SLOTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_cmd        i_cmd,
    input  logic [SLOTS-1:0] i_blockers,
    input  logic [SLOTS-1:0] i_rel_mask,
    input  logic             i_rel_self,
    input  logic             i_free_in,
    output logic             o_free_out,
    output t_cell_stat       o_stat
);

    logic              r_valid;
    logic [SLOTS-1:0]  r_blk;
    logic [FILE_W-1:0] r_file;
    logic [START_W-1:0] r_first;
    logic [LAST_W-1:0] r_last;
    logic              r_shared;

    logic              n_valid;
    logic [SLOTS-1:0]  n_blk;
    logic              w_pick;
    logic              w_overlap;
    logic              w_touched;
    logic [SLOTS-1:0]  w_left;

    assign o_free_out = i_free_in | ~r_valid;
    assign w_pick     = i_cmd.alloc & ~r_valid & ~i_free_in;

    assign w_overlap = ((LAST_W'(r_first) <= LAST_W'(i_cmd.first)) &&
                        (r_last >= LAST_W'(i_cmd.first))) ||
                       ((LAST_W'(i_cmd.first) <= LAST_W'(r_first)) &&
                        (i_cmd.last >= LAST_W'(r_first)));

    assign w_touched = |(r_blk & i_rel_mask);
    assign w_left    = r_blk & ~i_rel_mask;

    always_comb begin
        o_stat.valid = r_valid;
        o_stat.hit   = r_valid && (r_file == i_cmd.file) && w_overlap &&
                       !(r_shared && i_cmd.shared);
        o_stat.wake  = r_valid && !i_rel_self && w_touched && (w_left == '0);
        o_stat.pick  = w_pick;
    end

    always_comb begin
        n_valid = r_valid;
        n_blk   = r_blk;
        if (w_pick) begin
            n_valid = 1'b1;
            n_blk   = i_blockers;
        end else if (i_rel_self) begin
            n_valid = 1'b0;
            n_blk   = '0;
        end else if (w_touched) begin
            n_blk = w_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_blk   <= '0;
        end else begin
            r_valid <= n_valid;
            r_blk   <= n_blk;
        end
        if (w_pick) begin
            r_file   <= i_cmd.file;
            r_first  <= i_cmd.first;
            r_last   <= i_cmd.last;
            r_shared <= i_cmd.shared;
        end
    end

endmodule

[design/byte_range_lock_table_top.sv]
// Byte-range lock table built as a row of slot cells with a free-slot chain.
// The result beat is shown in the cycle after the execute cycle.
// A new command is not taken while busy is high; busy is high in the execute cycle,
// when every cell compares against the request and the free chain picks a slot.
// Reset is synchronous and active low; it frees every slot at once.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module byte_range_lock_table_top
    import brlt_pkg::*;
#(
    parameter int LOCK_SLOTS = LOCK_SLOTS_DEF,
    parameter int FILE_COUNT = FILE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cmd,
    input  logic [FILE_W-1:0]     i_file_id,
    input  logic [START_W-1:0]    i_range_start,
    input  logic [LENGTH_W-1:0]   i_range_length,
    input  logic                  i_read_only,
    input  logic [SLOT_OUT_W-1:0] i_release_slot,
    output logic                  o_result_valid,
    output logic [SLOT_OUT_W-1:0] o_slot,
    output logic                  o_granted,
    output logic [WAKE_W-1:0]     o_wake_mask,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int SLOT_W = $clog2(LOCK_SLOTS);

    logic                  r_exec;
    logic                  r_cmd;
    logic [FILE_W-1:0]     r_file;
    logic [START_W-1:0]    r_first;
    logic [LAST_W-1:0]     r_last;
    logic                  r_shared;
    logic                  r_zero;
    logic [SLOT_OUT_W-1:0] r_rs;

    logic                  r_out_valid;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic                  r_granted;
    logic [WAKE_W-1:0]     r_wake;
    logic [STATUS_W-1:0]   r_status;

    logic [SLOT_OUT_W-1:0] n_slot;
    logic                  n_granted;
    logic [WAKE_W-1:0]     n_wake;
    logic [STATUS_W-1:0]   n_status;

    logic                  w_accept;
    logic [FILE_W-1:0]     w_file_map [FILE_IDS];
    t_cell_cmd             w_cmd;
    t_cell_stat            w_stat [LOCK_SLOTS];
    logic [LOCK_SLOTS:0]   w_free;
    logic [LOCK_SLOTS-1:0] w_blockers;
    logic [LOCK_SLOTS-1:0] w_wakes;
    logic [LOCK_SLOTS-1:0] w_rel_mask;
    logic                  w_held;
    logic [SLOT_W-1:0]     w_idx;

    assign w_accept = start & ~busy;
    assign busy     = r_exec;

    for (genvar v = 0; v < FILE_IDS; v++) begin : g_file_map
        assign w_file_map[v] = FILE_W'(v % FILE_COUNT);
    end

    always_comb begin
        w_cmd.alloc  = r_exec && (r_cmd == CMD_ACQUIRE) && !r_zero;
        w_cmd.file   = r_file;
        w_cmd.first  = r_first;
        w_cmd.last   = r_last;
        w_cmd.shared = r_shared;
    end

    always_comb begin
        w_rel_mask = '0;
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            w_rel_mask[i] = r_exec && (r_cmd == CMD_RELEASE) &&
                            (32'(r_rs) == i) && w_stat[i].valid;
        end
    end
    assign w_held = |w_rel_mask;

    assign w_free[0] = 1'b0;

    for (genvar g = 0; g < LOCK_SLOTS; g++) begin : g_cell
        brlt_cell #(
            .SLOTS (LOCK_SLOTS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_blockers (w_blockers),
            .i_rel_mask (w_rel_mask),
            .i_rel_self (w_rel_mask[g]),
            .i_free_in  (w_free[g]),
            .o_free_out (w_free[g+1]),
            .o_stat     (w_stat[g])
        );
        assign w_blockers[g] = w_stat[g].hit;
        assign w_wakes[g]    = w_stat[g].wake;
    end

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            if (w_stat[i].pick) begin
                w_idx = w_idx | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        n_slot    = '0;
        n_granted = 1'b0;
        n_wake    = '0;
        n_status  = ST_OK;
        if (r_cmd == CMD_ACQUIRE) begin
            if (r_zero) begin
                n_status = ST_ZERO_LEN;
            end else if (!w_free[LOCK_SLOTS]) begin
                n_status = ST_FULL;
            end else begin
                n_slot    = SLOT_OUT_W'(w_idx);
                n_granted = (w_blockers == '0);
            end
        end else begin
            n_slot = r_rs;
            if (w_held) begin
                n_wake = WAKE_W'(w_wakes);
            end else begin
                n_status = ST_NOT_HELD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exec      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_exec      <= w_accept;
            r_out_valid <= r_exec;
        end
        if (w_accept) begin
            r_cmd    <= i_cmd;
            r_file   <= w_file_map[i_file_id];
            r_first  <= i_range_start;
            r_last   <= LAST_W'(i_range_start) + LAST_W'(i_range_length) - LAST_W'(1);
            r_shared <= i_read_only;
            r_zero   <= (i_range_length == '0);
            r_rs     <= i_release_slot;
        end
        if (r_exec) begin
            r_slot    <= n_slot;
            r_granted <= n_granted;
            r_wake    <= n_wake;
            r_status  <= n_status;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_slot         = r_slot;
    assign o_granted      = r_granted;
    assign o_wake_mask    = r_wake;
    assign o_status       = r_status;

endmodule

[design/brlt_checker.sv]
`include "byte_range_lock_table_top_macros.svh"

module brlt_checker
    import brlt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  i_cmd,
    input logic [LENGTH_W-1:0]   i_range_length,
    input logic                  o_result_valid,
    input logic [SLOT_OUT_W-1:0] o_slot,
    input logic                  o_granted,
    input logic [WAKE_W-1:0]     o_wake_mask,
    input logic [STATUS_W-1:0]   o_status
);

    // A taken command beat occupies the block for its execute cycle.
    `BRLT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_result_valid)

    // Every execute cycle is followed by exactly one result beat.
    `BRLT_ASSERT_NEXT(a_busy_result, i_clk, i_rst_n, busy, o_result_valid && !busy)

    // A failed command grants nothing and wakes nobody.
    `BRLT_ASSERT_NOW(a_error_quiet, i_clk, i_rst_n, o_result_valid && (o_status != ST_OK),
        !o_granted && (o_wake_mask == '0))

    // An acquire of zero length reports that status in its result beat.
    `BRLT_ASSERT_NEXT(a_zero_len, i_clk, i_rst_n,
        start && !busy && (i_cmd == CMD_ACQUIRE) && (i_range_length == '0),
        ##1 (o_result_valid && (o_status == ST_ZERO_LEN) && (o_slot == '0)))

endmodule

bind byte_range_lock_table_top brlt_checker u_brlt_checker (.*);

[sim/byte_range_lock_table_top_tb.sv]
module byte_range_lock_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brlt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1030;
    localparam logic [START_W-1:0] START_TOP = '1;

    typedef struct packed {
        logic                  cmd;
        logic [FILE_W-1:0]     file_id;
        logic [START_W-1:0]    range_start;
        logic [LENGTH_W-1:0]   range_length;
        logic                  read_only;
        logic [SLOT_OUT_W-1:0] release_slot;
    } lock_cmd_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0] slot;
        logic                  granted;
        logic [WAKE_W-1:0]     wake_mask;
        logic [STATUS_W-1:0]   status;
    } lock_result_t;

    class lock_scoreboard;
        bit                          held[LOCK_SLOTS_DEF];
        logic [FILE_W-1:0]           owner_file[LOCK_SLOTS_DEF];
        logic [START_W-1:0]          first_byte[LOCK_SLOTS_DEF];
        logic [LAST_W-1:0]           last_byte[LOCK_SLOTS_DEF];
        bit                          shared_lock[LOCK_SLOTS_DEF];
        logic [LOCK_SLOTS_DEF-1:0]   waits_on[LOCK_SLOTS_DEF];
        lock_result_t                outcome_q[$];
        int                          errors;

        function new();
            errors = 0;
            for (int i = 0; i < LOCK_SLOTS_DEF; i++) begin
                held[i] = 1'b0;
                owner_file[i] = '0;
                first_byte[i] = '0;
                last_byte[i] = '0;
                shared_lock[i] = 1'b0;
                waits_on[i] = '0;
            end
        endfunction

        function int held_count();
            int n;
            n = 0;
            for (int i = 0; i < LOCK_SLOTS_DEF; i++) n += held[i];
            return n;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        function void note_command(lock_cmd_t c);
            lock_result_t              r;
            logic [FILE_W-1:0]         f;
            logic [LAST_W-1:0]         last;
            logic [LOCK_SLOTS_DEF-1:0] blockers;
            int                        free_slot;
            int                        rs;
            bit                        overlap;
            r = '0;
            if (c.cmd == CMD_ACQUIRE) begin
                f = FILE_W'(c.file_id % FILE_COUNT_DEF);
                free_slot = -1;
                for (int i = 0; i < LOCK_SLOTS_DEF; i++) begin
                    if (!held[i] && free_slot < 0) free_slot = i;
                end
                if (c.range_length == '0) begin
                    r.status = ST_ZERO_LEN;
                end else if (free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    last = LAST_W'(c.range_start) + LAST_W'(c.range_length) - 1'b1;
                    blockers = '0;
                    for (int i = 0; i < LOCK_SLOTS_DEF; i++) begin
                        if (held[i] && owner_file[i] == f) begin
                            overlap = (first_byte[i] <= c.range_start &&
                                       last_byte[i] >= c.range_start) ||
                                      (c.range_start <= first_byte[i] &&
                                       last >= first_byte[i]);
                            if (overlap && !(shared_lock[i] && c.read_only))
                                blockers[i] = 1'b1;
                        end
                    end
                    held[free_slot] = 1'b1;
                    owner_file[free_slot] = f;
                    first_byte[free_slot] = c.range_start;
                    last_byte[free_slot] = last;
                    shared_lock[free_slot] = c.read_only;
                    waits_on[free_slot] = blockers;
                    r.slot = SLOT_OUT_W'(free_slot);
                    r.granted = (blockers == '0);
                    r.status = ST_OK;
                end
            end else begin
                rs = int'(c.release_slot);
                r.slot = c.release_slot;
                if (rs >= LOCK_SLOTS_DEF || !held[rs]) begin
                    r.status = ST_NOT_HELD;
                end else begin
                    held[rs] = 1'b0;
                    waits_on[rs] = '0;
                    for (int i = 0; i < LOCK_SLOTS_DEF; i++) begin
                        if (held[i] && waits_on[i][rs]) begin
                            waits_on[i][rs] = 1'b0;
                            if (waits_on[i] == '0) r.wake_mask[i] = 1'b1;
                        end
                    end
                    r.status = ST_OK;
                end
            end
            outcome_q.push_back(r);
        endfunction

        function void compare_field(string name, longint unsigned want,
                                    longint unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h actual %0h",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(lock_result_t got);
            lock_result_t want;
            if (outcome_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, expected none actual %p",
                         $time, got);
            end else begin
                want = outcome_q.pop_front();
                compare_field("slot", want.slot, got.slot);
                compare_field("granted", want.granted, got.granted);
                compare_field("wake_mask", want.wake_mask, got.wake_mask);
                compare_field("status", want.status, got.status);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cmd = CMD_ACQUIRE;
    logic [FILE_W-1:0]     i_file_id = '0;
    logic [START_W-1:0]    i_range_start = '0;
    logic [LENGTH_W-1:0]   i_range_length = '0;
    logic                  i_read_only = 1'b0;
    logic [SLOT_OUT_W-1:0] i_release_slot = '0;
    logic                  o_result_valid;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic                  o_granted;
    logic [WAKE_W-1:0]     o_wake_mask;
    logic [STATUS_W-1:0]   o_status;

    lock_scoreboard sb = new();
    int cycle_count = 0;
    bit burst_mode;

    byte_range_lock_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_file_id      (i_file_id),
        .i_range_start  (i_range_start),
        .i_range_length (i_range_length),
        .i_read_only    (i_read_only),
        .i_release_slot (i_release_slot),
        .o_result_valid (o_result_valid),
        .o_slot         (o_slot),
        .o_granted      (o_granted),
        .o_wake_mask    (o_wake_mask),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result('{o_slot, o_granted, o_wake_mask, o_status});
    end

    // A beat is taken at the first rising edge with start high and busy low.
    task automatic send_beat(input lock_cmd_t c, input int gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c.cmd;
        i_file_id <= c.file_id;
        i_range_start <= c.range_start;
        i_range_length <= c.range_length;
        i_read_only <= c.read_only;
        i_release_slot <= c.release_slot;
        do @(posedge i_clk); while (busy);
        sb.note_command(c);
    endtask

    task automatic acquire(input logic [FILE_W-1:0] f, input logic [START_W-1:0] s,
                           input logic [LENGTH_W-1:0] len, input logic ro);
        lock_cmd_t c;
        c = '{CMD_ACQUIRE, f, s, len, ro, SLOT_OUT_W'($urandom)};
        send_beat(c, $urandom_range(0, 15));
    endtask

    task automatic release_lock(input logic [SLOT_OUT_W-1:0] rs);
        lock_cmd_t c;
        c = '{CMD_RELEASE, FILE_W'($urandom), START_W'({$urandom, $urandom}), $urandom,
              1'($urandom), rs};
        send_beat(c, $urandom_range(0, 15));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic lock_cmd_t random_beat();
        lock_cmd_t c;
        int occupied;
        int rs;
        c.file_id = FILE_W'($urandom);
        c.range_start = START_W'({$urandom, $urandom});
        c.range_length = $urandom;
        c.read_only = 1'($urandom);
        c.release_slot = SLOT_OUT_W'($urandom);
        occupied = sb.held_count();
        if ($urandom_range(0, 17) < occupied || $urandom_range(0, 15) == 0) begin
            c.cmd = CMD_RELEASE;
            if (occupied > 0 && $urandom_range(0, 7) != 0) begin
                do rs = $urandom_range(0, LOCK_SLOTS_DEF - 1); while (!sb.held[rs]);
                c.release_slot = SLOT_OUT_W'(rs);
            end
        end else begin
            c.cmd = CMD_ACQUIRE;
            if ($urandom_range(0, 7) != 0) c.file_id = FILE_W'($urandom_range(0, 2));
            case ($urandom_range(0, 7))
                0: ;
                1: c.range_start = START_TOP - START_W'($urandom_range(0, 63));
                default: c.range_start = START_W'($urandom_range(0, 127));
            endcase
            case ($urandom_range(0, 19))
                0: c.range_length = '0;
                1: ;
                2: c.range_length = '1;
                3: c.range_length = 32'd1;
                default: c.range_length = $urandom_range(1, 24);
            endcase
        end
        return c;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        release_lock(4'd0);
        acquire(6'd0, 48'd0, 32'd0, 1'b0);
        acquire(6'd63, START_TOP, '1, 1'b0);
        acquire(6'd63, 48'd0, 32'd1, 1'b1);
        acquire(6'd63, START_TOP, 32'd1, 1'b1);
        acquire(6'd0, 48'd100, 32'd10, 1'b1);
        acquire(6'd0, 48'd105, 32'd1, 1'b1);
        acquire(6'd0, 48'd109, 32'd5, 1'b0);
        acquire(6'd0, 48'd90, 32'd20, 1'b0);
        acquire(6'd1, 48'd100, 32'd10, 1'b0);
        release_lock(4'd3);
        release_lock(4'd0);
        release_lock(4'd4);
        release_lock(4'd5);
        for (int i = 0; i < 12; i++) acquire(6'd2, START_W'(i), 32'd8, i[0]);
        acquire(6'd5, 48'd0, 32'd1, 1'b0);
        acquire(6'd5, 48'd0, 32'd0, 1'b0);
        release_lock(4'd15);
        drain_results();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
            if (n % 250 == 249) drain_results();
            send_beat(random_beat(), burst_mode ? 0 : $urandom_range(0, 15));
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/brlt_pkg.sv
design/brlt_cell.sv
design/byte_range_lock_table_top.sv
design/brlt_checker.sv
sim/byte_range_lock_table_top_tb.sv
